// File: design/ntc_pkg.sv
package ntc_pkg;

  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int NUM_W     = 34;
  localparam int POS_W     = 6;
  localparam int QW        = 16;
  localparam int DW        = 47;
  localparam int TN_W      = 44;
  localparam int ROM_MAX   = 1024;
  localparam int ROM_W     = 25;

  localparam logic [23:0] T25_LN2_Q16 = 24'd13543790;
  localparam logic [30:0] T25_CENTI_K = 31'd1953955800;
  localparam logic [QW-1:0] ZERO_C_CENTI = 16'd27315;
  localparam logic signed [14:0] TEMP_LOW  = -15'sd4000;
  localparam logic signed [14:0] TEMP_HIGH = 15'sd15000;

  localparam logic [1:0] REG_BETA    = 2'd0;
  localparam logic [1:0] REG_REF     = 2'd1;
  localparam logic [1:0] REG_DIVIDER = 2'd2;
  localparam logic [1:0] REG_NOMINAL = 2'd3;

  typedef logic [ROM_W-1:0] rom_t [0:ROM_MAX];

  typedef struct packed {
    logic lo;
    logic hi;
  } sat_t;

  function automatic rom_t build_rom(input int ltb, input int fb);
    rom_t rom;
    longint unsigned m;
    longint unsigned acc;
    for (int i = 0; i <= ROM_MAX; i++) begin
      rom[i] = '0;
    end
    for (int i = 0; i < (1 << ltb); i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - ltb));
      acc = 0;
      for (int b = 0; b < fb + 1; b++) begin
        m = (m * m) >> 30;
        acc = acc << 1;
        if (m >= (64'd2 << 30)) begin
          acc = acc | 64'd1;
          m = m >> 1;
        end
      end
      rom[i] = ROM_W'((acc + 64'd1) >> 1);
    end
    rom[1 << ltb] = ROM_W'(64'd1 << fb);
    return rom;
  endfunction

  function automatic logic [POS_W-1:0] lead_pos(input logic [NUM_W-1:0] n);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (n[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: design/ntc_thermistor_temperature.sv
// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_sample_voltage
// out      output     out_valid, out_ready, out_temperature_centi, out_out_of_range
// cfg      input      cfg_we, cfg_idx, cfg_wdata
//
// One sample enters per cycle while the output is not stalled; each result passes
// through the 7 arithmetic stages, the 16 one-bit divider stages and the output register.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults. Each stage holds while the stage after it is full and stalled,
// so a stall at the output fills bubbles first and loses nothing.
module ntc_thermistor_temperature #(
  parameter int LOG_TABLE_BITS = ntc_pkg::LOG_TABLE_BITS_DEF,
  parameter int FRACTION_BITS  = ntc_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [16:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [16:0]         in_sample_voltage,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  out_temperature_centi,
  output logic                out_out_of_range
);
  import ntc_pkg::*;

  localparam int LTB  = LOG_TABLE_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int SH_N = NUM_W - 1 - LTB;
  localparam int LW   = POS_W + FB;
  localparam int MW   = LW + 24;
  localparam int NS   = 8 + QW;
  localparam int RIW  = $clog2(ROM_MAX + 1);
  localparam rom_t LOG_ROM = build_rom(LTB, FB);

  logic [12:0] beta_r;
  logic [12:0] ref_r;
  logic [16:0] div_r;
  logic [16:0] nom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= 13'd3950;
      ref_r  <= 13'd2500;
      div_r  <= 17'd10000;
      nom_r  <= 17'd10000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BETA:    beta_r <= cfg_wdata[12:0];
        REG_REF:     ref_r  <= cfg_wdata[12:0];
        REG_DIVIDER: div_r  <= cfg_wdata;
        REG_NOMINAL: nom_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  sat_t sat_r   [NS];
  sat_t sat_nxt [NS];

  // Stage 0: products for the divider ratio.
  logic [16:0]      vref;
  logic [NUM_W-1:0] num0_r, den0_r;

  assign vref = {ref_r, 4'b0};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num0_r <= NUM_W'(div_r * in_sample_voltage);
      den0_r <= NUM_W'((vref - in_sample_voltage) * nom_r);
    end
  end

  // Stage 1: leading one and normalization.
  logic [POS_W-1:0] pn, pd;
  logic [NUM_W-1:0] normn, normd;
  logic [POS_W-1:0] pn1_r, pd1_r;
  logic [NUM_W-2:0] nn1_r, nd1_r;

  assign pn    = lead_pos(num0_r);
  assign pd    = lead_pos(den0_r);
  assign normn = num0_r << (POS_W'(NUM_W - 1) - pn);
  assign normd = den0_r << (POS_W'(NUM_W - 1) - pd);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pn1_r <= pn;
      pd1_r <= pd;
      nn1_r <= normn[NUM_W-2:0];
      nd1_r <= normd[NUM_W-2:0];
    end
  end

  // Stage 2: table lookup and interpolation.
  logic [RIW-1:0]      idxn, idxd;
  logic [FB:0]         lon, hin, lod, hid;
  logic [FB+SH_N:0]    prn, prd;
  logic [POS_W-1:0]    pn2_r, pd2_r;
  logic [FB:0]         lon2_r, lod2_r;
  logic [FB:0]         ipn2_r, ipd2_r;

  assign idxn = RIW'(nn1_r[NUM_W-2 -: LTB]);
  assign idxd = RIW'(nd1_r[NUM_W-2 -: LTB]);
  assign lon  = LOG_ROM[idxn][FB:0];
  assign hin  = LOG_ROM[idxn + RIW'(1)][FB:0];
  assign lod  = LOG_ROM[idxd][FB:0];
  assign hid  = LOG_ROM[idxd + RIW'(1)][FB:0];
  assign prn  = (FB+SH_N+1)'((hin - lon) * nn1_r[SH_N-1:0]);
  assign prd  = (FB+SH_N+1)'((hid - lod) * nd1_r[SH_N-1:0]);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pn2_r  <= pn1_r;
      pd2_r  <= pd1_r;
      lon2_r <= lon;
      lod2_r <= lod;
      ipn2_r <= prn[FB+SH_N:SH_N];
      ipd2_r <= prd[FB+SH_N:SH_N];
    end
  end

  // Stage 3: log2 of ratio, sign and magnitude.
  logic [LW-1:0]        lgn, lgd;
  logic signed [LW:0]   lg;
  logic                 neg3_r;
  logic [LW-1:0]        abs3_r;

  assign lgn = {pn2_r, FB'(0)} + LW'(lon2_r) + LW'(ipn2_r);
  assign lgd = {pd2_r, FB'(0)} + LW'(lod2_r) + LW'(ipd2_r);
  assign lg  = $signed({1'b0, lgn}) - $signed({1'b0, lgd});

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      neg3_r <= lg[LW];
      abs3_r <= lg[LW] ? LW'(-lg) : lg[LW-1:0];
    end
  end

  // Stage 4: scale by 298.15 ln2 and form the numerator.
  logic [MW-1:0]   mag4_r;
  logic            neg4_r;
  logic [TN_W-1:0] tn4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      mag4_r <= MW'(abs3_r * T25_LN2_Q16);
      neg4_r <= neg3_r;
      tn4_r  <= TN_W'(beta_r * T25_CENTI_K);
    end
  end

  // Stage 5: denominator.
  logic [MW-1:0]       magrnd;
  logic [29:0]         magr;
  logic signed [31:0]  d5_r;
  logic [TN_W-1:0]     tn5_r;

  assign magrnd = mag4_r + (MW'(1) << (FB - 1));
  assign magr   = magrnd[FB+29:FB];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d5_r  <= neg4_r ? $signed({3'b0, beta_r, 16'b0}) - $signed({2'b0, magr})
                      : $signed({3'b0, beta_r, 16'b0}) + $signed({2'b0, magr});
      tn5_r <= tn4_r;
    end
  end

  // Stage 6: rounding bias and overflow check; then one quotient bit per stage.
  logic [DW-1:0] nd6;
  logic [DW-1:0] dsh6;
  logic          dneg;
  logic          ovf;
  logic [DW-1:0] dv_rem_r [QW+1];
  logic [30:0]   dv_d_r   [QW+1];
  logic [QW-1:0] dv_q_r   [QW+1];

  assign dneg = d5_r <= 32'sd0;
  assign nd6  = {3'b0, tn5_r} + {17'b0, d5_r[30:1]};
  assign dsh6 = {d5_r[30:0], 16'b0};
  assign ovf  = nd6 >= dsh6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      dv_rem_r[0] <= nd6;
      dv_d_r[0]   <= d5_r[30:0];
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW-1:0] trial;
    logic          ge;
    assign trial = {16'b0, dv_d_r[j]} << (QW - 1 - j);
    assign ge    = dv_rem_r[j] >= trial;
    always_ff @(posedge clk) begin
      if (adv[7+j]) begin
        dv_rem_r[j+1] <= ge ? dv_rem_r[j] - trial : dv_rem_r[j];
        dv_d_r[j+1]   <= dv_d_r[j];
        dv_q_r[j+1]   <= dv_q_r[j] | (ge ? (QW'(1) << (QW - 1 - j)) : QW'(0));
      end
    end
  end

  always_comb begin
    sat_nxt[0].lo = (in_sample_voltage >= vref) || (nom_r == '0) || (beta_r == '0);
    sat_nxt[0].hi = 1'b0;
    for (int k = 1; k < NS; k++) begin
      sat_nxt[k] = sat_r[k-1];
    end
    sat_nxt[1].hi = sat_r[0].hi || (num0_r == '0);
    sat_nxt[6].hi = sat_r[5].hi || dneg || ovf;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        sat_r[k] <= sat_nxt[k];
      end
    end
  end

  // Output stage: offset to Celsius and clamp.
  logic signed [QW+1:0] tc;
  logic signed [14:0]   temp_r;
  logic                 oor_r;

  assign tc = $signed({2'b0, dv_q_r[QW]}) - $signed({2'b0, ZERO_C_CENTI});

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      if (sat_r[NS-2].lo) begin
        temp_r <= TEMP_LOW;
        oor_r  <= 1'b1;
      end else if (sat_r[NS-2].hi) begin
        temp_r <= TEMP_HIGH;
        oor_r  <= 1'b1;
      end else if (tc < (QW+2)'(TEMP_LOW)) begin
        temp_r <= TEMP_LOW;
        oor_r  <= 1'b1;
      end else if (tc > (QW+2)'(TEMP_HIGH)) begin
        temp_r <= TEMP_HIGH;
        oor_r  <= 1'b1;
      end else begin
        temp_r <= tc[14:0];
        oor_r  <= 1'b0;
      end
    end
  end

  assign out_valid             = vld_r[NS-1];
  assign out_temperature_centi = temp_r;
  assign out_out_of_range      = oor_r;

endmodule
